// ===== sv/bti_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants of the breakpoint table interpolator
// Field widths, stream packing positions and operation codes.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int OP_W    = 2;
    localparam int TBL_W   = 2;
    localparam int ENTRY_W = 5;
    localparam int MASS_W  = 24;
    localparam int VAL_W   = 24;
    localparam int SEG_W   = 5;
    localparam int CFG_W   = 6;

    // Input stream packing.
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = OP_W + TBL_W;
    localparam int ENT_LSB   = 0;
    localparam int WD_LSB    = ENT_LSB + ENTRY_W;
    localparam int QM_LSB    = WD_LSB + VAL_W;

    // Output stream packing.
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_W-1:0] RESET_COUNT = 6'd21;

    typedef logic [MASS_W-1:0]       mass_t;
    typedef logic signed [VAL_W-1:0] value_t;

    typedef enum logic [OP_W-1:0] {
        OP_WR_MASS  = 2'd0,
        OP_WR_VALUE = 2'd1,
        OP_EVAL     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

endpackage
`default_nettype wire

// ===== sv/breakpoint_table_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator: piecewise linear table lookup
// Binary search over sorted breakpoint masses, clamping at both ends and
// linear interpolation with a serial fraction divider and one multiply.
// ----------------------------------------------------------------------------
// Write items (mass or table value) are taken while the block is idle, and
// the block stays ready. An evaluate item occupies the block until its result
// item is taken. It fetches the end breakpoints in S_RD_FIRST, S_RD_LAST and
// S_SETUP. Each search probe is one registered read of the mass memory in
// S_PROBE and one compare in S_CMP, for at most floor(log2(point_count))+1
// probes. A last S_PROBE step closes the search unless a probe hits the query
// exactly. After that a clamped result passes S_CLASS and S_CLAMP. An
// interpolated one passes S_CLASS, S_LOAD_LO, S_LOAD_HI, S_PREP, S_DIV, S_MUL
// and S_SUM; the restoring divider in S_DIV produces one fraction bit per
// cycle. The divider is skipped when the fraction is zero or saturates at
// 1.0. At point_count 21 the search takes at most five probes. The result
// waits in S_OUT while m_tready stays low. The memories are not cleared at
// reset; evaluate only after every breakpoint in use and its values are
// written.
module breakpoint_table_interpolator #(
    parameter int MAX_POINTS = 32,
    parameter int NUM_TABLES = 4,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration: point_count.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bti_pkg::CFG_W-1:0]      cfg_data,
    // tdata: entry_index[4:0], write_data[28:5], query_mass[52:29], zeros above.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bti_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: operation[1:0], table_select[3:2].
    input  wire logic [bti_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata: interp_value[23:0], segment_index[28:24], zeros above.
    output logic [bti_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: below_range[0], above_range[1].
    output logic [bti_pkg::M_TUSER_W-1:0]       m_tuser
);
    import bti_pkg::*;

    localparam int MAW    = $clog2(MAX_POINTS);
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int VDEPTH = NUM_TABLES * MAX_POINTS;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int FW     = FRAC_BITS + 1;
    localparam int DCW    = $clog2(FRAC_BITS + 1);
    localparam int DY_W   = VAL_W + 1;
    localparam int PW     = FW + 1 + DY_W;
    localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_SETUP,
        S_PROBE,
        S_CMP,
        S_CLASS,
        S_CLAMP,
        S_LOAD_LO,
        S_LOAD_HI,
        S_PREP,
        S_DIV,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

    function automatic logic [TBL_W-1:0] wrap_table(input logic [TBL_W-1:0] t);
        logic [TBL_W-1:0] r;
        r = t;
        for (int k = 0; k < 3; k++) begin
            if (32'(r) >= NUM_TABLES) r = r - TBL_W'(NUM_TABLES);
        end
        return r;
    endfunction

    // Input fields.
    op_t                in_op;
    logic [TBL_W-1:0]   in_tbl;
    logic [ENTRY_W-1:0] in_ent;
    logic [VAL_W-1:0]   in_wdata;
    mass_t              in_q;
    logic               s_accept;

    assign in_op    = op_t'(s_tuser[OP_W-1:0]);
    assign in_tbl   = s_tuser[OP_W+TBL_W-1:OP_W];
    assign in_ent   = s_tdata[ENT_LSB+ENTRY_W-1:ENT_LSB];
    assign in_wdata = s_tdata[WD_LSB+VAL_W-1:WD_LSB];
    assign in_q     = s_tdata[QM_LSB+MASS_W-1:QM_LSB];
    assign s_accept = s_tvalid && s_tready;

    logic [MAW+ENTRY_W-1:0] ent_wide;
    logic [MAW-1:0]         ent_addr;
    logic                   ent_ok;
    logic [VAW-1:0]         in_base;

    assign ent_wide = (MAW+ENTRY_W)'(in_ent);
    assign ent_addr = ent_wide[MAW-1:0];
    assign ent_ok   = 32'(in_ent) < MAX_POINTS;
    assign in_base  = VAW'(32'(wrap_table(in_tbl)) * MAX_POINTS);

    // Registers.
    state_t            state_reg;
    logic [CFG_W-1:0]  point_count_reg;
    mass_t             q_reg;
    logic [VAW-1:0]    base_reg;
    logic [CW-1:0]     last_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     mid_reg;
    logic [CW-1:0]     idx_reg;
    logic              idx_neg_reg;
    mass_t             m_first_reg;
    mass_t             m_last_reg;
    logic [MAW-1:0]    seg_reg;
    logic              below_reg;
    logic              above_reg;
    mass_t             m0_reg;
    mass_t             m1_reg;
    value_t            y0_reg;
    value_t            y1_reg;
    logic signed [DY_W-1:0] dy_reg;
    logic [MASS_W:0]   rem_reg;
    mass_t             d_reg;
    logic [FW-1:0]     frac_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic signed [PW-1:0] prod_reg;
    value_t            m_val_reg;
    logic              m_tvalid_reg;

    // Memories.
    mass_t  mass_mem [MAX_POINTS];
    value_t value_mem [VDEPTH];
    mass_t  mass_rdata_reg;
    value_t value_rdata_reg;

    logic            mass_we;
    logic            value_we;
    logic            mass_re;
    logic            value_re;
    logic [MAW-1:0]  mass_raddr;
    logic [VAW-1:0]  value_raddr;

    assign mass_we  = s_accept && (in_op == OP_WR_MASS) && ent_ok;
    assign value_we = s_accept && (in_op == OP_WR_VALUE) && ent_ok;

    always_ff @(posedge aclk) begin
        if (mass_we) begin
            mass_mem[ent_addr] <= in_wdata;
        end
        if (mass_re) begin
            mass_rdata_reg <= mass_mem[mass_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (value_we) begin
            value_mem[in_base + VAW'(ent_addr)] <= value_t'(in_wdata);
        end
        if (value_re) begin
            value_rdata_reg <= value_mem[value_raddr];
        end
    end

    // Used point count, saturated into its legal range.
    logic [CW-1:0] n_used;
    always_comb begin
        if (point_count_reg < CFG_W'(2)) begin
            n_used = CW'(2);
        end else if (32'(point_count_reg) > MAX_POINTS) begin
            n_used = CW'(MAX_POINTS);
        end else begin
            n_used = CW'(point_count_reg);
        end
    end

    logic [CW-1:0] mid_c;
    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Classification of the search result against both ends.
    logic           below_c;
    logic           above_c;
    logic           clamp_first_c;
    logic           clamp_last_c;
    logic [MAW-1:0] seg_c;
    logic [MAW-1:0] seg_inc;

    always_comb begin
        below_c       = q_reg < m_first_reg;
        above_c       = !below_c && (q_reg > m_last_reg);
        clamp_first_c = below_c || (!above_c && idx_neg_reg);
        clamp_last_c  = above_c || (!clamp_first_c && (idx_reg >= last_reg));
        if (clamp_first_c) begin
            seg_c = '0;
        end else if (clamp_last_c) begin
            seg_c = last_reg[MAW-1:0];
        end else begin
            seg_c = idx_reg[MAW-1:0];
        end
    end

    assign seg_inc = seg_reg + MAW'(1);

    always_comb begin
        mass_re     = 1'b0;
        value_re    = 1'b0;
        mass_raddr  = '0;
        value_raddr = '0;
        case (state_reg)
            S_RD_FIRST: begin
                mass_re = 1'b1;
            end
            S_RD_LAST: begin
                mass_re    = 1'b1;
                mass_raddr = last_reg[MAW-1:0];
            end
            S_PROBE: begin
                mass_re    = 1'b1;
                mass_raddr = mid_c[MAW-1:0];
            end
            S_CLASS: begin
                mass_re     = 1'b1;
                value_re    = 1'b1;
                mass_raddr  = seg_c;
                value_raddr = base_reg + VAW'(seg_c);
            end
            S_LOAD_LO: begin
                mass_re     = 1'b1;
                value_re    = 1'b1;
                mass_raddr  = seg_inc;
                value_raddr = base_reg + VAW'(seg_inc);
            end
            default: begin
                mass_re = 1'b0;
            end
        endcase
    end

    // Fraction setup and divider step.
    mass_t         span_c;
    mass_t         offs_c;
    logic [MASS_W:0] rem_sh;
    logic          div_bit;
    logic signed [PW-1:0] prod_shift;
    logic [VAL_W-1:0] sum_c;

    assign span_c     = m1_reg - m0_reg;
    assign offs_c     = q_reg - m0_reg;
    assign rem_sh     = {rem_reg[MASS_W-1:0], 1'b0};
    assign div_bit    = rem_sh >= {1'b0, d_reg};
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign sum_c      = prod_shift[VAL_W-1:0] + y0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            point_count_reg <= RESET_COUNT;
        end else begin
            if (cfg_valid) begin
                point_count_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept && (in_op == OP_EVAL)) begin
                        q_reg     <= in_q;
                        base_reg  <= in_base;
                        last_reg  <= n_used - CW'(1);
                        hi_reg    <= n_used;
                        lo_reg    <= '0;
                        state_reg <= S_RD_FIRST;
                    end
                end
                S_RD_FIRST: begin
                    state_reg <= S_RD_LAST;
                end
                S_RD_LAST: begin
                    m_first_reg <= mass_rdata_reg;
                    state_reg   <= S_SETUP;
                end
                S_SETUP: begin
                    m_last_reg <= mass_rdata_reg;
                    state_reg  <= S_PROBE;
                end
                S_PROBE: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= mid_c;
                        state_reg <= S_CMP;
                    end else begin
                        idx_reg     <= hi_reg - CW'(1);
                        idx_neg_reg <= (hi_reg == '0);
                        state_reg   <= S_CLASS;
                    end
                end
                S_CMP: begin
                    if (mass_rdata_reg == q_reg) begin
                        idx_reg     <= mid_reg;
                        idx_neg_reg <= 1'b0;
                        state_reg   <= S_CLASS;
                    end else begin
                        if (mass_rdata_reg < q_reg) begin
                            lo_reg <= mid_reg + CW'(1);
                        end else begin
                            hi_reg <= mid_reg;
                        end
                        state_reg <= S_PROBE;
                    end
                end
                S_CLASS: begin
                    seg_reg   <= seg_c;
                    below_reg <= below_c;
                    above_reg <= above_c;
                    if (clamp_first_c || clamp_last_c) begin
                        state_reg <= S_CLAMP;
                    end else begin
                        state_reg <= S_LOAD_LO;
                    end
                end
                S_CLAMP: begin
                    m_val_reg    <= value_rdata_reg;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_LOAD_LO: begin
                    m0_reg    <= mass_rdata_reg;
                    y0_reg    <= value_rdata_reg;
                    state_reg <= S_LOAD_HI;
                end
                S_LOAD_HI: begin
                    m1_reg    <= mass_rdata_reg;
                    y1_reg    <= value_rdata_reg;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    dy_reg <= DY_W'(y1_reg) - DY_W'(y0_reg);
                    if (!((m1_reg > m0_reg) && (q_reg > m0_reg))) begin
                        frac_reg  <= '0;
                        state_reg <= S_MUL;
                    end else if (offs_c >= span_c) begin
                        // The quotient reaches 1.0 or more and saturates there.
                        frac_reg  <= FRAC_ONE;
                        state_reg <= S_MUL;
                    end else begin
                        rem_reg     <= {1'b0, offs_c};
                        d_reg       <= span_c;
                        frac_reg    <= '0;
                        div_cnt_reg <= DCW'(FRAC_BITS);
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_bit) begin
                        rem_reg <= rem_sh - {1'b0, d_reg};
                    end else begin
                        rem_reg <= rem_sh;
                    end
                    frac_reg    <= {frac_reg[FW-2:0], div_bit};
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                    if (div_cnt_reg == DCW'(1)) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= $signed({1'b0, frac_reg}) * dy_reg;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    // The arithmetic shift floors the product, also when negative.
                    m_val_reg    <= sum_c;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    logic [MAW+SEG_W-1:0] seg_wide;
    assign seg_wide = (MAW+SEG_W)'(seg_reg);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W-VAL_W-SEG_W){1'b0}}, seg_wide[SEG_W-1:0], m_val_reg};
    assign m_tuser   = {above_reg, below_reg};

    // Checks.
    a_ready_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result item is pending");

    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_op == OP_EVAL)) |=> !s_tready)
        else $error("ready right after an evaluate item");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("below and above range both set");

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (frac_reg <= FRAC_ONE))
        else $error("fraction above one");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg != '0))
        else $error("divider running with an empty count");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the breakpoint table interpolator
// Items from a pending queue are driven into the block with random gaps. A
// shadow copy of the breakpoint and value tables predicts each evaluation.
// The monitor stalls the result side at random and compares every result item
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import bti_pkg::*;

    localparam int MAX_POINTS     = 32;
    localparam int NUM_TABLES     = 4;
    localparam int FRAC_BITS      = 16;
    localparam int WORK_ITEMS     = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum {REQ_ITEM, REQ_COUNT, REQ_PAUSE} req_kind_t;

    typedef struct {
        req_kind_t          kind;
        op_t                op;
        logic [TBL_W-1:0]   tbl;
        logic [ENTRY_W-1:0] entry;
        logic [VAL_W-1:0]   wdata;
        logic [MASS_W-1:0]  qmass;
        logic [CFG_W-1:0]   count;
    } request_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             below;
        logic             above;
        logic [SEG_W-1:0] seg;
    } interp_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    breakpoint_table_interpolator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Shadow state of the block, updated as items are accepted.
    logic [MASS_W-1:0]       bp_mass [MAX_POINTS];
    logic signed [VAL_W-1:0] tbl_val [NUM_TABLES][MAX_POINTS];
    logic [CFG_W-1:0]        point_count_q = RESET_COUNT;

    // Generator view of the masses, used to aim queries at the segments.
    logic [MASS_W-1:0] gen_mass [MAX_POINTS];
    logic [CFG_W-1:0]  gen_count = RESET_COUNT;
    int                work_items = 0;

    request_t       pending_items [$];
    interp_result_t expected_results [$];
    int             mismatches = 0;

    function automatic int used_points(logic [CFG_W-1:0] cnt);
        if (cnt < 2) return 2;
        if (cnt > MAX_POINTS) return MAX_POINTS;
        return cnt;
    endfunction

    function automatic interp_result_t interp_predict(logic [TBL_W-1:0] tbl,
                                                      logic [MASS_W-1:0] q);
        interp_result_t r;
        int n, last, lo, hi, mid, idx;
        bit hit;
        longint qv, m0, m1, y0, y1, frac, p;
        n    = used_points(point_count_q);
        last = n - 1;
        lo   = 0;
        hi   = n;
        hit  = 0;
        idx  = 0;
        while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (bp_mass[mid] == q) begin
                hit = 1;
                idx = mid;
            end else if (bp_mass[mid] < q) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (!hit) idx = hi - 1;
        r.below = 1'b0;
        r.above = 1'b0;
        // The below check wins over the above check when the list is unsorted.
        if (q < bp_mass[0]) begin
            r.below = 1'b1;
            r.seg   = '0;
            r.value = tbl_val[tbl][0];
        end else if (q > bp_mass[last]) begin
            r.above = 1'b1;
            r.seg   = SEG_W'(last);
            r.value = tbl_val[tbl][last];
        end else if (idx < 0) begin
            r.seg   = '0;
            r.value = tbl_val[tbl][0];
        end else if (idx >= last) begin
            r.seg   = SEG_W'(last);
            r.value = tbl_val[tbl][last];
        end else begin
            qv   = q;
            m0   = bp_mass[idx];
            m1   = bp_mass[idx + 1];
            y0   = tbl_val[tbl][idx];
            y1   = tbl_val[tbl][idx + 1];
            frac = 0;
            if (m1 > m0 && qv > m0) begin
                frac = ((qv - m0) << FRAC_BITS) / (m1 - m0);
                if (frac > (64'sd1 << FRAC_BITS)) frac = 64'sd1 << FRAC_BITS;
            end
            // Arithmetic shift floors the product toward minus infinity.
            p       = frac * (y1 - y0);
            r.seg   = SEG_W'(idx);
            r.value = VAL_W'(y0 + (p >>> FRAC_BITS));
        end
        return r;
    endfunction

    // Number of idle cycles before the next item; calm stretches have none.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 6);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    request_t             cur_req;
    bit                   s_busy = 0;
    bit                   cfg_busy = 0;
    int                   gap_left = 0;
    int                   s_calm = 0;
    int                   settle = 0;
    logic [S_TDATA_W-1:0] tdata_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid      <= 1'b0;
            cfg_valid     <= 1'b0;
            s_busy        = 0;
            cfg_busy      = 0;
            point_count_q = RESET_COUNT;
        end else begin
            if (s_tvalid && s_tready) begin
                s_busy = 0;
                case (cur_req.op)
                    OP_WR_MASS:  bp_mass[cur_req.entry] = cur_req.wdata;
                    OP_WR_VALUE: tbl_val[cur_req.tbl][cur_req.entry] = cur_req.wdata;
                    OP_EVAL:
                        expected_results.push_back(interp_predict(cur_req.tbl,
                                                                  cur_req.qmass));
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready) begin
                cfg_busy      = 0;
                point_count_q = cur_req.count;
            end
            if (!s_busy && !cfg_busy && pending_items.size() > 0) begin
                if (pending_items[0].kind == REQ_ITEM) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        cur_req  = pending_items.pop_front();
                        s_busy   = 1;
                        gap_left = draw_wait(s_calm);
                    end
                end else begin
                    // Register writes and pauses wait until the block has gone idle.
                    if (expected_results.size() == 0) settle++;
                    else settle = 0;
                    if (settle >= SETTLE_CYCLES) begin
                        settle  = 0;
                        cur_req = pending_items.pop_front();
                        if (cur_req.kind == REQ_COUNT) cfg_busy = 1;
                    end
                end
            end
            tdata_next = '0;
            tdata_next[ENT_LSB +: ENTRY_W] = cur_req.entry;
            tdata_next[WD_LSB +: VAL_W]    = cur_req.wdata;
            tdata_next[QM_LSB +: MASS_W]   = cur_req.qmass;
            s_tvalid  <= s_busy;
            s_tdata   <= tdata_next;
            s_tuser   <= {cur_req.tbl, cur_req.op};
            cfg_valid <= cfg_busy;
            cfg_data  <= cur_req.count;
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    interp_result_t want;
    int             m_calm = 0;
    int             stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no expected result pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.value) begin
                        $error("interp_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(m_tdata[VAL_W-1:0]));
                        mismatches++;
                    end
                    if (m_tdata[VAL_W +: SEG_W] !== want.seg) begin
                        $error("segment_index: expected %0d, actual %0d",
                               want.seg, m_tdata[VAL_W +: SEG_W]);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.below) begin
                        $error("below_range: expected %0d, actual %0d",
                               want.below, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== want.above) begin
                        $error("above_range: expected %0d, actual %0d",
                               want.above, m_tuser[1]);
                        mismatches++;
                    end
                end
                stall_left = draw_wait(m_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no channel moves for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic put_item(op_t op, logic [TBL_W-1:0] tbl, logic [ENTRY_W-1:0] entry,
                            logic [VAL_W-1:0] wdata, logic [MASS_W-1:0] qmass);
        request_t r;
        r.kind  = REQ_ITEM;
        r.op    = op;
        r.tbl   = tbl;
        r.entry = entry;
        r.wdata = wdata;
        r.qmass = qmass;
        r.count = gen_count;
        pending_items.push_back(r);
        if (op == OP_WR_MASS) gen_mass[entry] = wdata;
        work_items++;
    endtask

    task automatic put_eval(logic [TBL_W-1:0] tbl, logic [MASS_W-1:0] q);
        put_item(OP_EVAL, tbl, 5'($urandom), 24'($urandom), q);
    endtask

    task automatic put_control(req_kind_t kind, logic [CFG_W-1:0] count);
        request_t r;
        r.kind  = kind;
        r.op    = OP_NONE;
        r.tbl   = '0;
        r.entry = '0;
        r.wdata = '0;
        r.qmass = '0;
        r.count = count;
        pending_items.push_back(r);
        if (kind == REQ_COUNT) gen_count = count;
    endtask

    // Ascending masses in all entries; a step of zero makes a duplicate.
    task automatic load_masses(int style);
        logic [MASS_W-1:0] m;
        int step_max;
        step_max = (style == 0) ? 16 : (style == 1) ? 'h3FFF : 'h7FFF0;
        m = 24'($urandom_range(1, 'h3FF));
        for (int e = 0; e < MAX_POINTS; e++) begin
            put_item(OP_WR_MASS, 2'($urandom), 5'(e), m, 24'($urandom));
            m = m + 24'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_max));
        end
    endtask

    task automatic load_values(logic [TBL_W-1:0] tbl, int style);
        logic [VAL_W-1:0] v;
        for (int e = 0; e < MAX_POINTS; e++) begin
            v = (style == 0) ? 24'($urandom_range(0, 8191) - 4096) : 24'($urandom);
            put_item(OP_WR_VALUE, tbl, 5'(e), v, 24'($urandom));
        end
    endtask

    function automatic logic [MASS_W-1:0] pick_query();
        int n, i;
        logic [MASS_W-1:0] m0, m1, top;
        n   = used_points(gen_count);
        i   = $urandom_range(0, n - 2);
        m0  = gen_mass[i];
        m1  = gen_mass[i + 1];
        top = gen_mass[n - 1];
        case ($urandom_range(0, 7))
            0: return 24'($urandom);
            1: return m0;
            2, 3: return (m1 > m0) ? 24'($urandom_range(m0, m1)) : m0;
            4: return m0 + 24'd1;
            5: return (gen_mass[0] > 0) ? 24'($urandom_range(0, gen_mass[0] - 1)) : 24'd0;
            6: return top;
            default: return (top < 24'hFFFFFF) ? 24'($urandom_range(top + 1, 24'hFFFFFF))
                                               : top;
        endcase
    endfunction

    initial begin
        int burst, pick, entry;
        logic [MASS_W-1:0] lo, hi;

        // Every mass and every table value is written before the first evaluation.
        load_masses(2);
        for (int t = 0; t < NUM_TABLES; t++) load_values(2'(t), t % 2);

        // Directed part at the reset point count.
        put_eval(0, 24'd0);
        put_eval(1, gen_mass[0]);
        put_eval(2, gen_mass[10]);
        put_eval(3, gen_mass[10] + (gen_mass[11] - gen_mass[10]) / 2);
        put_eval(0, gen_mass[11] - 24'd1);
        put_eval(1, gen_mass[20]);
        put_eval(2, gen_mass[20] + 24'd1);
        put_eval(3, 24'hFFFFFF);
        put_item(OP_NONE, 2'd3, 5'd31, 24'hFFFFFF, 24'hFFFFFF);
        // Full-scale swing between two neighboring values.
        put_item(OP_WR_VALUE, 2'd2, 5'd3, 24'h7FFFFF, 24'd0);
        put_item(OP_WR_VALUE, 2'd2, 5'd4, 24'h800000, 24'd0);
        put_eval(2, gen_mass[3] + (gen_mass[4] - gen_mass[3]) / 3);
        // A duplicate breakpoint and an out-of-order one.
        put_item(OP_WR_MASS, 2'd0, 5'd6, gen_mass[5], 24'd0);
        put_eval(1, gen_mass[5]);
        put_item(OP_WR_MASS, 2'd1, 5'd8, gen_mass[7] / 2, 24'd0);
        put_eval(3, gen_mass[7] + 24'd5);
        put_eval(0, gen_mass[8] + 24'd1);
        // Point count extremes, including values that saturate.
        put_control(REQ_COUNT, 6'd2);
        put_eval(1, gen_mass[0] + 24'd1);
        put_eval(2, gen_mass[1]);
        put_control(REQ_COUNT, 6'd32);
        put_eval(3, gen_mass[31]);
        put_eval(0, gen_mass[30] + 24'd1);
        put_control(REQ_COUNT, 6'd0);
        put_eval(1, gen_mass[1] + 24'd1);
        put_control(REQ_COUNT, 6'd63);
        put_eval(2, gen_mass[31] + 24'd1);

        // Random part: phases with a point count, optional reloads and a burst.
        load_masses(1);
        while (work_items < WORK_ITEMS) begin
            if ($urandom_range(0, 3) == 0) load_masses($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0) load_values(2'($urandom), $urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: put_control(REQ_COUNT, 6'd1);
                1: put_control(REQ_COUNT, 6'($urandom_range(33, 63)));
                2: put_control(REQ_COUNT, 6'd32);
                3: put_control(REQ_COUNT, 6'd2);
                default: put_control(REQ_COUNT, 6'($urandom_range(2, 32)));
            endcase
            burst = $urandom_range(15, 40);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    put_eval(2'($urandom), pick_query());
                end else if (pick < 82) begin
                    put_item(OP_WR_VALUE, 2'($urandom), 5'($urandom), 24'($urandom),
                             24'($urandom));
                end else if (pick < 88) begin
                    entry = $urandom_range(0, MAX_POINTS - 1);
                    lo = (entry > 0) ? gen_mass[entry - 1] : 24'd0;
                    hi = (entry < MAX_POINTS - 1) ? gen_mass[entry + 1] : 24'hFFFFFF;
                    // Mostly keep the list sorted; sometimes break it.
                    if (pick < 86 && hi >= lo)
                        put_item(OP_WR_MASS, 2'($urandom), 5'(entry),
                                 24'($urandom_range(lo, hi)), 24'($urandom));
                    else
                        put_item(OP_WR_MASS, 2'($urandom), 5'(entry), 24'($urandom),
                                 24'($urandom));
                end else if (pick < 93) begin
                    put_item(OP_NONE, 2'($urandom), 5'($urandom), 24'($urandom),
                             24'($urandom));
                end else if (pick < 95) begin
                    put_control(REQ_PAUSE, gen_count);
                end else begin
                    put_eval(2'($urandom), ($urandom_range(0, 1) == 0) ? 24'd0 : 24'hFFFFFF);
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_busy || cfg_busy ||
               expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bti_pkg.sv
sv/breakpoint_table_interpolator.sv
test/testbench.sv
